// File: rtl/hsv_to_rgb_pixel_defines.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_defines.svh
// Assertion macros used by the HSV to RGB pixel converter RTL.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define H2R_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h2r assertion failed");

// Check that a condition implies another in the next cycle
`define H2R_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h2r assertion failed");

`else

`define H2R_ASSERT_IMP(label, clk, rst, ante, cons)
`define H2R_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Widths, fixed-point constants, sector codes and pipeline control types
// for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

   // Field widths
   localparam int HUE_W = 16;
   localparam int CH_W  = 8;
   localparam int SEC_W = 3;

   // Hue scaling: one degree is 2^HUE_FRAC_BITS hue units
   localparam int HUE_FRAC_BITS   = 6;
   localparam int SECTOR_UNITS    = 60 << HUE_FRAC_BITS;
   localparam int FULL_TURN_UNITS = 360 << HUE_FRAC_BITS;
   localparam int THR_W           = HUE_W + 2;
   localparam int REM_W           = $clog2(SECTOR_UNITS);
   localparam int M_W             = $clog2(SECTOR_UNITS + 1);

   // Level numerator: v * (DEN - s * m), DEN = 255 * SECTOR_UNITS
   localparam int DEN    = 255 * SECTOR_UNITS;
   localparam int DEN_W  = $clog2(DEN + 1);
   localparam int PROD_W = CH_W + M_W;
   localparam int X_W    = CH_W + DEN_W;

   // After dropping the hue fraction bits the divisor is 255 * 60
   localparam int DIV      = 255 * 60;
   localparam int Y_W      = $clog2(255 * DIV + 1);
   localparam int RECIP_SH = 24;
   localparam int RECIP    = (1 << RECIP_SH) / DIV;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int PQ_W     = Y_W + RECIP_W;

   // Sector codes
   localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
   localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
   localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
   localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
   localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
   localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

   // Stage load enables for one level lane
   typedef struct packed {
      logic st2;
      logic st3;
      logic st4;
   } pipe_en_type;

   // Start of a sector in hue units
   function automatic logic [THR_W-1:0] sector_base(input logic [SEC_W-1:0] sec);
      logic [THR_W-1:0] base;
      base = THR_W'(int'(sec) * SECTOR_UNITS);
      return base;
   endfunction

endpackage

`default_nettype wire

// File: rtl/hsv_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// HSV to RGB pixel converter: sector split, three level lanes (P, Q, T)
// and a sector routing stage with an output register.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_hue, req_saturation,
//                       req_brightness
//   rsp      out        rsp_valid, rsp_stall, rsp_red, rsp_green, rsp_blue
//
// One pixel per clock while rsp_stall is low.
// The five register stages (sector split, complement product, brightness
// product, reciprocal estimate, routed output) each hold one transaction.
// A stage loads when it is empty or the next stage loads, so bubbles close
// up under a rsp stall and req_stall rises only when all stages are full.
// Synchronous reset clears the valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_pixel_defines.svh"

module hsv_to_rgb_pixel (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [h2r_pkg::HUE_W-1:0]    req_hue,
   input  wire logic [h2r_pkg::CH_W-1:0]     req_saturation,
   input  wire logic [h2r_pkg::CH_W-1:0]     req_brightness,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [h2r_pkg::CH_W-1:0]     rsp_red,
   output logic      [h2r_pkg::CH_W-1:0]     rsp_green,
   output logic      [h2r_pkg::CH_W-1:0]     rsp_blue
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   logic v1_in, v2_in, v3_in, v4_in, out_v_in;
   logic en1, en2, en3, en4, en5;
   h2r_pkg::pipe_en_type lane_en;

   logic [h2r_pkg::SEC_W-1:0] sector_ff;
   logic [h2r_pkg::REM_W-1:0] rem_ff;
   logic [h2r_pkg::CH_W-1:0]  sat_ff;
   logic [h2r_pkg::CH_W-1:0]  bright_ff;
   logic [h2r_pkg::SEC_W-1:0] sec2_ff, sec3_ff, sec4_ff;

   logic [h2r_pkg::M_W-1:0]   m_p, m_q, m_t;
   logic [h2r_pkg::CH_W-1:0]  lvl_p, lvl_q, lvl_t, lvl_v;
   logic [h2r_pkg::CH_W-1:0]  bright2_ff, bright3_ff, bright4_ff;
   logic [h2r_pkg::CH_W-1:0]  red_in, green_in, blue_in;
   logic [h2r_pkg::CH_W-1:0]  red_ff, green_ff, blue_ff;

   // Stage load enables: load when empty or when the next stage loads
   always_comb begin
      en5         = !out_v_ff || !rsp_stall;
      en4         = !v4_ff || en5;
      en3         = !v3_ff || en4;
      en2         = !v2_ff || en3;
      en1         = !v1_ff || en2;
      req_stall   = !en1;
      lane_en.st2 = en2;
      lane_en.st3 = en3;
      lane_en.st4 = en4;
      v1_in       = en1 ? req_valid : v1_ff;
      v2_in       = en2 ? v1_ff     : v2_ff;
      v3_in       = en3 ? v2_ff     : v3_ff;
      v4_in       = en4 ? v3_ff     : v4_ff;
      out_v_in    = en5 ? v4_ff     : out_v_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         out_v_ff <= out_v_in;
      end
   end

   // Stage one: sector split
   h2r_sector u_sector (
      .clock     (clock),
      .en        (en1),
      .hue       (req_hue),
      .sat       (req_saturation),
      .bright    (req_brightness),
      .sector_ff (sector_ff),
      .rem_ff    (rem_ff),
      .sat_ff    (sat_ff),
      .bright_ff (bright_ff)
   );

   // Per-level multipliers of saturation
   always_comb begin
      m_p = h2r_pkg::M_W'(h2r_pkg::SECTOR_UNITS);
      m_q = h2r_pkg::M_W'(rem_ff);
      m_t = h2r_pkg::M_W'(h2r_pkg::M_W'(h2r_pkg::SECTOR_UNITS) - h2r_pkg::M_W'(rem_ff));
   end

   h2r_level u_level_p (
      .clock  (clock),
      .en     (lane_en),
      .sat    (sat_ff),
      .bright (bright_ff),
      .mult   (m_p),
      .level  (lvl_p)
   );

   h2r_level u_level_q (
      .clock  (clock),
      .en     (lane_en),
      .sat    (sat_ff),
      .bright (bright_ff),
      .mult   (m_q),
      .level  (lvl_q)
   );

   h2r_level u_level_t (
      .clock  (clock),
      .en     (lane_en),
      .sat    (sat_ff),
      .bright (bright_ff),
      .mult   (m_t),
      .level  (lvl_t)
   );

   // Carry sector and brightness alongside the lanes
   always_ff @(posedge clock) begin
      if (en2) begin
         sec2_ff    <= sector_ff;
         bright2_ff <= bright_ff;
      end
      if (en3) begin
         sec3_ff    <= sec2_ff;
         bright3_ff <= bright2_ff;
      end
      if (en4) begin
         sec4_ff    <= sec3_ff;
         bright4_ff <= bright3_ff;
      end
   end

   // Route levels to channels by sector
   always_comb begin
      lvl_v = bright4_ff;
      case (sec4_ff)
         h2r_pkg::SEC_0: begin
            red_in = lvl_v;  green_in = lvl_t;  blue_in = lvl_p;
         end
         h2r_pkg::SEC_1: begin
            red_in = lvl_q;  green_in = lvl_v;  blue_in = lvl_p;
         end
         h2r_pkg::SEC_2: begin
            red_in = lvl_p;  green_in = lvl_v;  blue_in = lvl_t;
         end
         h2r_pkg::SEC_3: begin
            red_in = lvl_p;  green_in = lvl_q;  blue_in = lvl_v;
         end
         h2r_pkg::SEC_4: begin
            red_in = lvl_t;  green_in = lvl_p;  blue_in = lvl_v;
         end
         default: begin
            red_in = lvl_v;  green_in = lvl_p;  blue_in = lvl_q;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en5) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // An accepted transaction always lands in stage one
   `H2R_ASSERT_NXT(a_accept_loads, clock, reset, req_valid && !req_stall, v1_ff)
   // An empty output register means the whole pipeline can take input
   `H2R_ASSERT_IMP(a_empty_ready, clock, reset, !out_v_ff, !req_stall)
   // Stage one never holds a sector past the last one
   `H2R_ASSERT_IMP(a_sector_range, clock, reset, v1_ff, sector_ff <= h2r_pkg::SEC_5)
   // A finished stage four moves into the output register
   `H2R_ASSERT_NXT(a_stage4_out, clock, reset, v4_ff && en4, out_v_ff)

endmodule

`default_nettype wire

// File: rtl/h2r_sector.sv
// ----------------------------------------------------------------------------
// h2r_sector
// First pipeline stage: splits the hue into sector and remainder, both zero
// at a full turn or more, and registers them with saturation and brightness.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2r_sector (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [h2r_pkg::HUE_W-1:0]      hue,
   input  wire logic [h2r_pkg::CH_W-1:0]       sat,
   input  wire logic [h2r_pkg::CH_W-1:0]       bright,
   output logic      [h2r_pkg::SEC_W-1:0]      sector_ff,
   output logic      [h2r_pkg::REM_W-1:0]      rem_ff,
   output logic      [h2r_pkg::CH_W-1:0]       sat_ff,
   output logic      [h2r_pkg::CH_W-1:0]       bright_ff
);

   logic [h2r_pkg::THR_W-1:0] hue_x;
   logic                      wrap;
   logic [h2r_pkg::SEC_W-1:0] sector_in;
   logic [h2r_pkg::REM_W-1:0] rem_in;

   // Find the sector by comparing against each sector start after the first
   always_comb begin
      hue_x     = h2r_pkg::THR_W'(hue);
      wrap      = (hue_x >= h2r_pkg::THR_W'(h2r_pkg::FULL_TURN_UNITS));
      sector_in = h2r_pkg::SEC_0;
      for (int k = 1; k < 6; k++) begin
         if (hue_x >= h2r_pkg::sector_base(h2r_pkg::SEC_W'(k))) begin
            sector_in = h2r_pkg::SEC_W'(k);
         end
      end
      if (wrap) begin
         sector_in = h2r_pkg::SEC_0;
         rem_in    = '0;
      end else begin
         rem_in = h2r_pkg::REM_W'(hue_x - h2r_pkg::sector_base(sector_in));
      end
   end

   // Load stage one
   always_ff @(posedge clock) begin
      if (en) begin
         sector_ff <= sector_in;
         rem_ff    <= rem_in;
         sat_ff    <= sat;
         bright_ff <= bright;
      end
   end

endmodule

`default_nettype wire

// File: rtl/h2r_level.sv
// ----------------------------------------------------------------------------
// h2r_level
// One level lane: forms floor(v * (DEN - s * m) / DEN) over three register
// stages and a final correction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2r_level (
   input  wire logic                        clock,
   input  wire h2r_pkg::pipe_en_type        en,
   input  wire logic [h2r_pkg::CH_W-1:0]    sat,
   input  wire logic [h2r_pkg::CH_W-1:0]    bright,
   input  wire logic [h2r_pkg::M_W-1:0]     mult,
   output logic      [h2r_pkg::CH_W-1:0]    level
);

   logic [h2r_pkg::PROD_W-1:0] sm_prod;
   logic [h2r_pkg::DEN_W-1:0]  diff_in;
   logic [h2r_pkg::DEN_W-1:0]  diff_ff;
   logic [h2r_pkg::CH_W-1:0]   bright_ff;
   logic [h2r_pkg::X_W-1:0]    num;
   logic [h2r_pkg::Y_W-1:0]    y_in;
   logic [h2r_pkg::Y_W-1:0]    y_ff;
   logic [h2r_pkg::PQ_W-1:0]   recip_prod;
   logic [h2r_pkg::CH_W-1:0]   qe_in;
   logic [h2r_pkg::CH_W-1:0]   qe_ff;
   logic [h2r_pkg::Y_W-1:0]    y4_ff;
   logic [h2r_pkg::Y_W-1:0]    back;
   logic [h2r_pkg::Y_W-1:0]    resid;

   // Stage two: scaled complement DEN - s * m
   always_comb begin
      sm_prod = h2r_pkg::PROD_W'(sat) * h2r_pkg::PROD_W'(mult);
      diff_in = h2r_pkg::DEN_W'(h2r_pkg::PROD_W'(h2r_pkg::DEN) - sm_prod);
   end

   always_ff @(posedge clock) begin
      if (en.st2) begin
         diff_ff   <= diff_in;
         bright_ff <= bright;
      end
   end

   // Stage three: multiply by brightness, drop the hue fraction bits
   always_comb begin
      num  = h2r_pkg::X_W'(bright_ff) * h2r_pkg::X_W'(diff_ff);
      y_in = h2r_pkg::Y_W'(num >> h2r_pkg::HUE_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en.st3) begin
         y_ff <= y_in;
      end
   end

   // Stage four: reciprocal estimate, low by at most one
   always_comb begin
      recip_prod = h2r_pkg::PQ_W'(y_ff) * h2r_pkg::PQ_W'(h2r_pkg::RECIP);
      qe_in      = h2r_pkg::CH_W'(recip_prod >> h2r_pkg::RECIP_SH);
   end

   always_ff @(posedge clock) begin
      if (en.st4) begin
         qe_ff <= qe_in;
         y4_ff <= y_ff;
      end
   end

   // Correct the estimate with one compare
   always_comb begin
      back  = h2r_pkg::Y_W'(qe_ff) * h2r_pkg::Y_W'(h2r_pkg::DIV);
      resid = y4_ff - back;
      level = qe_ff + h2r_pkg::CH_W'(resid >= h2r_pkg::Y_W'(h2r_pkg::DIV));
   end

endmodule

`default_nettype wire
